// ===== hdl/f2c_pkg.sv =====
// shared constants for the frenet to cartesian converter
package f2c_pkg;
    localparam int MAX_WAYPOINTS = 256;
    localparam int IDX_W = 8;
    localparam int UNIT_BITS = 30;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;
    localparam logic [1:0] REG_COUNT = 2'd0;
endpackage

// ===== hdl/f2c_table.sv =====
// waypoint table: three synchronous memories with one write and one read port
module f2c_table
    import f2c_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_arc,
    input  logic [31:0]      wr_east,
    input  logic [31:0]      wr_north,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_arc,
    output logic [31:0]      rd_east,
    output logic [31:0]      rd_north
);
    logic [31:0] arc_mem [MAX_WAYPOINTS];
    logic [31:0] east_mem [MAX_WAYPOINTS];
    logic [31:0] north_mem [MAX_WAYPOINTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            arc_mem[wr_addr] <= wr_arc;
            east_mem[wr_addr] <= wr_east;
            north_mem[wr_addr] <= wr_north;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_arc <= arc_mem[rd_addr];
        rd_east <= east_mem[rd_addr];
        rd_north <= north_mem[rd_addr];
    end
endmodule

// ===== hdl/frenet_to_cartesian.sv =====
// frenet to cartesian converter top level
// write transfer: accepted while idle, no result
// convert transfer: result valid after a scan over the clamped count and the steps below
// (table reads, sqrt, x and y divide, multiply, sum; no divide at zero length)
// one item at a time; next input accepted the cycle after the result transfer
// async active-low reset clears control and waypoint_count to 1; table is unset
module frenet_to_cartesian
    import f2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [7:0]         wp_index,
    input  logic [31:0]        wp_arc,
    input  logic signed [31:0] wp_east,
    input  logic signed [31:0] wp_north,
    input  logic [31:0]        query_arc,
    input  logic signed [31:0] query_lateral,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_east,
    output logic signed [31:0] out_north,
    output logic [7:0]         segment_start,
    output logic               clipped
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_RDS   = 4'd2;
    localparam logic [3:0] S_RDE   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_GETE  = 4'd9;

    logic [3:0] state_reg;
    logic [8:0] count_reg;
    logic [8:0] ncnt;
    logic [8:0] scan_reg;
    logic scan_rd_reg;
    logic [IDX_W-1:0] start_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0] q_reg;
    logic signed [31:0] lat_reg;
    logic [31:0] arc_s_reg;
    logic signed [31:0] east_s_reg, north_s_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0] ax_reg, ay_reg;
    logic [63:0] rem_reg;
    logic [63:0] sq_v_reg;
    logic [31:0] root_reg;
    logic [5:0] step_reg;
    logic div_sel_reg;
    logic [61:0] num_reg;
    logic [31:0] quo_reg;
    logic [31:0] dre_reg;
    logic signed [31:0] ux_reg, uy_reg;
    logic [1:0] mstep_reg;
    logic signed [34:0] p_reg [4];
    logic [31:0] rd_arc, rd_east, rd_north;
    logic wr_en;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_COUNT) ? {23'd0, count_reg} : 32'd0;
    assign in_stall = (state_reg != S_IDLE);
    assign wr_en = in_valid && !in_stall && (cmd == CMD_WRITE);
    assign ncnt = (count_reg == 9'd0) ? 9'd1 :
                  (count_reg > 9'(MAX_WAYPOINTS)) ? 9'(MAX_WAYPOINTS) : count_reg;

    // table read address
    always_comb
    begin
        case (state_reg)
            S_SCAN:  rd_addr = scan_reg[IDX_W-1:0];
            S_RDS:   rd_addr = start_reg;
            default: rd_addr = (9'(start_reg) + 9'd1 < ncnt) ? start_reg + 8'd1 : 8'd0;
        endcase
    end

    f2c_table u_table (
        .clk(clk), .wr_en(wr_en), .wr_addr(wp_index), .wr_arc(wp_arc),
        .wr_east(wp_east), .wr_north(wp_north), .rd_addr(rd_addr),
        .rd_arc(rd_arc), .rd_east(rd_east), .rd_north(rd_north)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 9'd1;
        else if (psel && penable && pwrite && pready && paddr == REG_COUNT)
            count_reg <= pwdata[8:0];
    end

    // division step: shift-subtract on num/len
    logic [32:0] dtrial;
    assign dtrial = {dre_reg, num_reg[61]} - {1'b0, root_reg};

    // multiply operands for rounded unit products
    logic signed [32:0] ma;
    logic signed [31:0] mu;
    always_comb
    begin
        case (mstep_reg)
            2'd0: begin ma = 33'($signed({1'b0, q_reg})) - 33'($signed({1'b0, arc_s_reg})); mu = ux_reg; end
            2'd1: begin ma = 33'(lat_reg); mu = uy_reg; end
            2'd2: begin ma = 33'($signed({1'b0, q_reg})) - 33'($signed({1'b0, arc_s_reg})); mu = uy_reg; end
            default: begin ma = 33'(lat_reg); mu = ux_reg; end
        endcase
    end
    logic [32:0] mag_a;
    logic [31:0] mag_u;
    logic [64:0] mprod;
    logic [34:0] mround;
    assign mag_a = ma[32] ? 33'(-ma) : 33'(ma);
    assign mag_u = mu[31] ? 32'(-mu) : 32'(mu);
    assign mprod = 65'(mag_a) * 65'(mag_u);
    assign mround = 35'((mprod + (65'(1) << (UNIT_BITS - 1))) >> UNIT_BITS);

    logic signed [35:0] sum_e, sum_n;
    assign sum_e = 36'(east_s_reg) + 36'(p_reg[0]) + 36'(p_reg[1]);
    assign sum_n = 36'(north_s_reg) + 36'(p_reg[2]) - 36'(p_reg[3]);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && cmd == CMD_CONVERT)
                    begin
                        q_reg <= query_arc;
                        lat_reg <= query_lateral;
                        scan_reg <= 9'd0;
                        scan_rd_reg <= 1'b0;
                        start_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // compare the word read last cycle
                    if (scan_rd_reg && rd_arc < q_reg)
                        start_reg <= 8'(scan_reg - 9'd1);
                    scan_rd_reg <= 1'b1;
                    if (scan_reg == ncnt)
                        state_reg <= S_RDS;
                    else
                        scan_reg <= scan_reg + 9'd1;
                end
                S_RDS:
                    state_reg <= S_GETE;
                S_GETE:
                begin
                    arc_s_reg <= rd_arc;
                    east_s_reg <= rd_east;
                    north_s_reg <= rd_north;
                    state_reg <= S_RDE;
                end
                S_RDE:
                begin
                    logic signed [32:0] dx, dy;
                    logic [32:0] ax, ay;
                    dx = 33'(signed'(rd_east)) - 33'(east_s_reg);
                    dy = 33'(signed'(rd_north)) - 33'(north_s_reg);
                    ax = dx[32] ? 33'(-dx) : 33'(dx);
                    ay = dy[32] ? 33'(-dy) : 33'(dy);
                    if (ax[32] || ax[31] || ay[32] || ay[31])
                    begin
                        ax = ax >> 1;
                        ay = ay >> 1;
                    end
                    dx_reg <= dx;
                    dy_reg <= dy;
                    ax_reg <= ax[31:0];
                    ay_reg <= ay[31:0];
                    mstep_reg <= 2'd0;
                    step_reg <= 6'd0;
                    root_reg <= 32'd0;
                    rem_reg <= 64'd0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    // step 0 squares the components, then 32 restoring steps
                    if (step_reg == 6'd0)
                    begin
                        if (mstep_reg == 2'd0)
                        begin
                            sq_v_reg <= 64'(ax_reg) * 64'(ax_reg);
                            mstep_reg <= 2'd1;
                        end
                        else
                        begin
                            sq_v_reg <= sq_v_reg + 64'(ay_reg) * 64'(ay_reg);
                            mstep_reg <= 2'd0;
                            step_reg <= 6'd32;
                        end
                    end
                    else
                    begin
                        logic [63:0] rem_try, trial;
                        // bring down the next two radicand bits
                        rem_try = {rem_reg[61:0], sq_v_reg[63:62]};
                        trial = {30'd0, root_reg, 2'b01};
                        if (rem_try >= trial)
                        begin
                            rem_reg <= rem_try - trial;
                            root_reg <= {root_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_try;
                            root_reg <= {root_reg[30:0], 1'b0};
                        end
                        sq_v_reg <= {sq_v_reg[61:0], 2'b00};
                        step_reg <= step_reg - 6'd1;
                        if (step_reg == 6'd1)
                        begin
                            div_sel_reg <= 1'b0;
                            num_reg <= {ax_reg, 30'd0};
                            dre_reg <= 32'd0;
                            quo_reg <= 32'd0;
                            step_reg <= 6'd62;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (root_reg == 32'd0)
                    begin
                        ux_reg <= 32'sd1 <<< UNIT_BITS;
                        uy_reg <= 32'sd0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        logic [31:0] nq;
                        if (!dtrial[32])
                        begin
                            dre_reg <= dtrial[31:0];
                            nq = {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            dre_reg <= {dre_reg[30:0], num_reg[61]};
                            nq = {quo_reg[30:0], 1'b0};
                        end
                        quo_reg <= nq;
                        num_reg <= {num_reg[60:0], 1'b0};
                        step_reg <= step_reg - 6'd1;
                        if (step_reg == 6'd1)
                        begin
                            if (!div_sel_reg)
                            begin
                                ux_reg <= dx_reg[32] ? 32'(-nq) : 32'(nq);
                                div_sel_reg <= 1'b1;
                                num_reg <= {ay_reg, 30'd0};
                                dre_reg <= 32'd0;
                                quo_reg <= 32'd0;
                                step_reg <= 6'd62;
                            end
                            else
                            begin
                                uy_reg <= dy_reg[32] ? 32'(-nq) : 32'(nq);
                                state_reg <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    p_reg[mstep_reg] <= (ma[32] != mu[31]) ? 35'(-mround) : 35'(mround);
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    logic ce, cn;
                    ce = (sum_e > 36'sd2147483647) || (sum_e < -36'sd2147483648);
                    cn = (sum_n > 36'sd2147483647) || (sum_n < -36'sd2147483648);
                    out_east <= (sum_e > 36'sd2147483647) ? 32'h7fffffff :
                                (sum_e < -36'sd2147483648) ? 32'h80000000 : sum_e[31:0];
                    out_north <= (sum_n > 36'sd2147483647) ? 32'h7fffffff :
                                 (sum_n < -36'sd2147483648) ? 32'h80000000 : sum_n[31:0];
                    clipped <= ce || cn;
                    segment_start <= start_reg;
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // result present only while waiting in the output state
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> in_stall)
        else $error("input accepted during scan");
    a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 9'(segment_start) < ncnt)
        else $error("segment start beyond count");
endmodule
